// File: design/irhr_pkg.sv
`timescale 1ns / 1ps

package irhr_pkg;

  // Input beat kinds carried on tuser.
  typedef enum logic [2:0] {
    KIND_POLL   = 3'd0,
    KIND_ACK    = 3'd1,
    KIND_TICK   = 3'd2,
    KIND_KEYPAD = 3'd3,
    KIND_JOY    = 3'd4
  } kind_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_ACK_DELAY = 2'd0;
  localparam logic [1:0] REG_GAP_DELAY = 2'd1;

  localparam logic [15:0] ACK_DELAY_RESET = 16'd30;
  localparam logic [15:0] GAP_DELAY_RESET = 16'd1000;

  // Keypad and message constants.
  localparam int          KEY_COUNT  = 20;
  localparam int          KEY_W      = 20;
  localparam logic [5:0]  SHIFT_CODE = 6'h24;
  localparam int          SHIFT_POS  = 3;
  localparam logic [3:0]  JOY_CENTER = 4'd7;
  localparam logic [3:0]  JOY_MAX    = 4'd14;
  localparam logic [3:0]  JOY_SAT_IN = 4'd15;

  // One entry of the per-unit table.
  typedef struct packed {
    logic [KEY_W-1:0] key_sample;
    logic [7:0]       joy_sample;
    logic [5:0]       last_key;
    logic [7:0]       last_joy;
  } unit_entry_t;

  localparam int ENTRY_W = $bits(unit_entry_t);

  // Outcome of a keypad check.
  typedef struct packed {
    logic       post;
    logic [5:0] code;
  } key_result_t;

  function automatic logic [2:0] gray3(input logic [2:0] m);
    return m ^ (m >> 1);
  endfunction

  // Joystick message from a latched position (x in bits 3..0, y in 7..4).
  function automatic logic [11:0] joy_message(input logic [7:0] cur, input logic [1:0] u);
    logic [3:0] x;
    logic [3:0] y;
    logic [3:0] mx;
    logic [3:0] my;
    logic       sx;
    logic       sy;
    x  = cur[3:0];
    y  = cur[7:4];
    sx = (x <= JOY_CENTER);
    sy = (y <= JOY_CENTER);
    mx = sx ? (JOY_CENTER - x) : (x - JOY_CENTER);
    my = sy ? (JOY_CENTER - y) : (y - JOY_CENTER);
    return {1'b0, sy, gray3(my[2:0]), sx, gray3(mx[2:0]), u, 1'b1};
  endfunction

  function automatic logic [11:0] key_message(input logic [5:0] code, input logic [1:0] u);
    return {2'b00, code, 1'b0, u, 1'b0};
  endfunction

  // Priority-encoded key with shift tracking and held-key suppression.
  function automatic key_result_t key_eval(input logic [KEY_W-1:0] kb,
                                           input logic [5:0] prev);
    key_result_t      res;
    logic [31:0]      kb_ext;
    logic             shift;
    logic             held;
    logic             found;
    logic [4:0]       idx;
    logic [KEY_W-1:0] masked;
    kb_ext = {{(32-KEY_W){1'b0}}, kb};
    shift  = kb[SHIFT_POS];
    held   = (prev != 6'd0) && (prev != SHIFT_CODE) && kb_ext[prev[4:0]];
    masked = kb;
    masked[SHIFT_POS] = 1'b0;
    found  = 1'b0;
    idx    = 5'd0;
    // Walk down so that the lowest pressed key wins.
    for (int i = KEY_COUNT - 1; i >= 0; i--) begin
      if (masked[i]) begin
        found = 1'b1;
        idx   = 5'(i + 1);
      end
    end
    if (held) begin
      res.post = (prev[5] != shift);
      res.code = {shift, prev[4:0]};
    end else begin
      if (found) begin
        res.code = {shift, idx};
      end else if (shift) begin
        res.code = SHIFT_CODE;
      end else begin
        res.code = 6'd0;
      end
      res.post = (res.code != prev);
    end
    return res;
  endfunction

endpackage

// File: design/irhr_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM with a registered read.
module irhr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AddrW-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: design/ir_handset_receiver.sv
`timescale 1ns / 1ps
// Path: an acknowledge, unknown or plain tick beat goes from acceptance through ST_DONE to its
// result beat, a sample beat through ST_SAMPLE and ST_DONE, a poll or a tick that sends the last
// nibble through ST_SCAN_RD and ST_SCAN_EV for each unit checked (joysticks first, then keypads).
// Throughput: one beat at a time; the next beat is taken the cycle after the result is loaded.
// Reset (rst, synchronous) clears the handshake state and the registers to 30 and 1000; the
// per-unit table reads as zero until each entry is first written.
module ir_handset_receiver #(
  parameter int NUM_UNITS = 4
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: ack_level[0], unit[2:1], key_bits[22:3], joy_x[26:23], joy_y[30:27], pad[31]
  input  logic [31:0] s_axis_tdata,
  // tuser: kind[2:0]
  input  logic [2:0]  s_axis_tuser,
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: int_line[0], data_nibble[4:1], clock_level[5], nibbles_left[7:6]
  output logic [7:0]  m_axis_tdata,
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AddrW = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
  localparam int VDepth = 1 << AddrW;
  localparam logic [2:0] UnitLimit = 3'(NUM_UNITS);
  localparam logic [1:0] LastUnit = 2'(NUM_UNITS - 1);
  localparam int ENTRY_W_L = irhr_pkg::ENTRY_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SAMPLE,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_DONE
  } state_t;

  state_t state;

  // Input fields.
  logic [2:0]  in_kind;
  logic        in_ack;
  logic [1:0]  in_unit;
  logic [19:0] in_keys;
  logic [3:0]  in_jx;
  logic [3:0]  in_jy;

  assign in_kind = s_axis_tuser;
  assign in_ack  = s_axis_tdata[0];
  assign in_unit = s_axis_tdata[2:1];
  assign in_keys = s_axis_tdata[22:3];
  assign in_jx   = s_axis_tdata[26:23];
  assign in_jy   = s_axis_tdata[30:27];

  // Latched item.
  logic [2:0]  item_kind;
  logic [1:0]  item_unit;
  logic [19:0] item_keys;
  logic [7:0]  item_joy;

  // Configuration registers.
  logic [15:0] ack_ticks;
  logic [15:0] gap_ticks;

  // Handshake state.
  logic [11:0] msg_buf;
  logic [1:0]  pending;
  logic        clock_flag;
  logic        ack_flag;
  logic        intr;
  logic [15:0] delay_count;
  logic        delay_armed;

  // Poll sequencer.
  logic [1:0]  scan_idx;
  logic        scan_key;
  logic        scan_single;

  // Table access.
  logic [VDepth-1:0]         entry_valid;
  logic                      rd_valid;
  logic [AddrW-1:0]          rd_addr;
  logic [ENTRY_W_L-1:0]      ram_q;
  logic                      ram_we;
  logic [AddrW-1:0]          ram_waddr;
  irhr_pkg::unit_entry_t     rd_entry;
  irhr_pkg::unit_entry_t     wr_entry;

  // Evaluation of the entry under scan.
  logic                  joy_change;
  irhr_pkg::key_result_t key_res;
  logic                  do_post;
  logic [11:0]           post_msg;

  // Derived control values.
  logic [3:0]  jx_sat;
  logic [3:0]  jy_sat;
  logic [1:0]  pending_dec;
  logic [1:0]  recheck_unit;

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;

  assign jx_sat       = (in_jx == irhr_pkg::JOY_SAT_IN) ? irhr_pkg::JOY_MAX : in_jx;
  assign jy_sat       = (in_jy == irhr_pkg::JOY_SAT_IN) ? irhr_pkg::JOY_MAX : in_jy;
  assign pending_dec  = pending - 2'd1;
  assign recheck_unit = ~msg_buf[2:1];

  // The accepted beat's unit is read while idle; the scan index otherwise.
  assign rd_addr = (state == ST_IDLE) ? in_unit[AddrW-1:0] : scan_idx[AddrW-1:0];

  irhr_ram #(
    .WIDTH(ENTRY_W_L),
    .DEPTH(NUM_UNITS)
  ) u_table (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(wr_entry),
    .rd_addr(rd_addr),
    .rd_data(ram_q)
  );

  // Entries never written read as zero.
  assign rd_entry = rd_valid ? irhr_pkg::unit_entry_t'(ram_q) : '0;

  // Check of the unit under scan.
  always_comb begin
    joy_change = (rd_entry.joy_sample != rd_entry.last_joy);
    key_res    = irhr_pkg::key_eval(rd_entry.key_sample, rd_entry.last_key);
    if (scan_key) begin
      do_post  = key_res.post;
      post_msg = irhr_pkg::key_message(key_res.code, scan_idx);
    end else begin
      do_post  = joy_change;
      post_msg = irhr_pkg::joy_message(rd_entry.joy_sample, scan_idx);
    end
  end

  // Table write-back for samples and for posted messages.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = scan_idx[AddrW-1:0];
    wr_entry  = rd_entry;
    case (state)
      ST_SAMPLE: begin
        ram_waddr = item_unit[AddrW-1:0];
        ram_we    = ({1'b0, item_unit} < UnitLimit);
        if (item_kind == irhr_pkg::KIND_KEYPAD) begin
          wr_entry.key_sample = item_keys;
        end else begin
          wr_entry.joy_sample = item_joy;
        end
      end
      ST_SCAN_EV: begin
        ram_we = do_post;
        if (scan_key) begin
          wr_entry.last_key = key_res.code;
        end else begin
          wr_entry.last_joy = rd_entry.joy_sample;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer, handshake state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      ack_ticks     <= irhr_pkg::ACK_DELAY_RESET;
      gap_ticks     <= irhr_pkg::GAP_DELAY_RESET;
      msg_buf       <= '0;
      pending       <= '0;
      clock_flag    <= 1'b0;
      ack_flag      <= 1'b0;
      intr          <= 1'b0;
      delay_count   <= '0;
      delay_armed   <= 1'b0;
      entry_valid   <= '0;
      rd_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
      scan_idx      <= '0;
      scan_key      <= 1'b0;
      scan_single   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == irhr_pkg::REG_ACK_DELAY) begin
          ack_ticks <= cfg_data;
        end else if (cfg_index == irhr_pkg::REG_GAP_DELAY) begin
          gap_ticks <= cfg_data;
        end
      end

      // The result register is reloaded in ST_DONE; elsewhere a taken beat empties it.
      if (m_axis_tvalid && m_axis_tready && state != ST_DONE) begin
        m_axis_tvalid <= 1'b0;
      end

      rd_valid <= entry_valid[rd_addr];
      if (ram_we) begin
        entry_valid[ram_waddr] <= 1'b1;
      end

      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            item_kind <= in_kind;
            item_unit <= in_unit;
            item_keys <= in_keys;
            item_joy  <= {jy_sat, jx_sat};
            case (in_kind)
              irhr_pkg::KIND_POLL: begin
                if (pending == 2'd0) begin
                  scan_idx    <= '0;
                  scan_key    <= 1'b0;
                  scan_single <= 1'b0;
                  state       <= ST_SCAN_RD;
                end else if (pending == 2'd3 && {1'b0, recheck_unit} < UnitLimit) begin
                  // Recheck the unit whose message is still waiting.
                  scan_idx    <= recheck_unit;
                  scan_key    <= msg_buf[0];
                  scan_single <= 1'b1;
                  state       <= ST_SCAN_RD;
                end else begin
                  state <= ST_DONE;
                end
              end
              irhr_pkg::KIND_ACK: begin
                state <= ST_DONE;
                if (pending != 2'd0 && in_ack != ack_flag) begin
                  ack_flag <= in_ack;
                  if (in_ack == clock_flag) begin
                    delay_count <= ack_ticks;
                    delay_armed <= 1'b1;
                  end
                end
              end
              irhr_pkg::KIND_TICK: begin
                if (delay_armed && delay_count <= 16'd1) begin
                  if (pending != 2'd0) begin
                    clock_flag <= ~clock_flag;
                    msg_buf    <= msg_buf >> 4;
                    pending    <= pending_dec;
                    intr       <= 1'b0;
                    // The gap delay follows the second nibble.
                    if (pending_dec == 2'd1) begin
                      delay_count <= gap_ticks;
                      delay_armed <= 1'b1;
                    end else begin
                      delay_count <= '0;
                      delay_armed <= 1'b0;
                    end
                    if (pending_dec == 2'd0) begin
                      scan_idx    <= '0;
                      scan_key    <= 1'b0;
                      scan_single <= 1'b0;
                      state       <= ST_SCAN_RD;
                    end else begin
                      state <= ST_DONE;
                    end
                  end else begin
                    delay_armed <= 1'b0;
                    delay_count <= '0;
                    state       <= ST_DONE;
                  end
                end else begin
                  if (delay_armed) begin
                    delay_count <= delay_count - 16'd1;
                  end
                  state <= ST_DONE;
                end
              end
              irhr_pkg::KIND_KEYPAD, irhr_pkg::KIND_JOY: begin
                state <= ST_SAMPLE;
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_SAMPLE: begin
          state <= ST_DONE;
        end
        ST_SCAN_RD: begin
          state <= ST_SCAN_EV;
        end
        ST_SCAN_EV: begin
          if (do_post) begin
            msg_buf    <= ~post_msg;
            pending    <= 2'd3;
            clock_flag <= 1'b1;
            intr       <= 1'b1;
            state      <= ST_DONE;
          end else if (scan_single) begin
            state <= ST_DONE;
          end else if (scan_idx == LastUnit) begin
            // Joysticks first, then the keypads.
            if (!scan_key) begin
              scan_key <= 1'b1;
              scan_idx <= '0;
              state    <= ST_SCAN_RD;
            end else begin
              state <= ST_DONE;
            end
          end else begin
            scan_idx <= scan_idx + 2'd1;
            state    <= ST_SCAN_RD;
          end
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {pending, clock_flag, msg_buf[3:0], intr};
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
